// ----- src/ipsp_pkg.sv -----
// shared types, codes and constants of the ips patch stream parser
package ipsp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_OFFSET  = 4'd1,
    PH_SIZE    = 4'd2,
    PH_LITERAL = 4'd3,
    PH_RUNLEN  = 4'd4,
    PH_FILL    = 4'd5,
    PH_DONE    = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IMG_W    = 25;
  localparam logic        REG_IMAGE_SIZE = 1'b0;

  localparam logic [IMG_W-1:0] IMAGE_LIMIT = 25'h1000000;
  localparam logic [23:0]      MAGIC_END   = 24'h454F46;

  // "PATCH", indexed modulo five
  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h50;
      3'd1:    val = 8'h41;
      3'd2:    val = 8'h54;
      3'd3:    val = 8'h43;
      3'd4:    val = 8'h48;
      3'd5:    val = 8'h50;
      3'd6:    val = 8'h41;
      3'd7:    val = 8'h54;
      default: val = 8'h50;
    endcase
    return val;
  endfunction

endpackage

// ----- src/ips_patch_stream_parser_core.sv -----
// ips patch stream parser: header check, record decode, write and fill commands
// path: an accepted item is held in the input register, then in the result register
// throughput: one item per cycle while out_ready does not stall the result, the parse state updates once per item
// items that arrive after a finish are dropped without a result until last_byte
// reset: synchronous active low rst_n clears the parse state, image_size and
// both pipeline valid flags
module ips_patch_stream_parser_core
  import ipsp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input item channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_patch_byte,
  input  logic                in_last_byte,
  // result item channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_write_valid,
  output logic [23:0]         out_write_address,
  output logic [7:0]          out_write_data,
  output logic [15:0]         out_fill_count,
  output logic [1:0]          out_status,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // configuration register
  logic [IMG_W-1:0] image_size_r;
  logic             cfg_write;

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [23:0] offset_r, offset_nxt;
  logic [15:0] size_r, size_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [23:0] wptr_r, wptr_nxt;

  // result register
  logic        out_valid_r;
  logic        res_wv_r;
  logic [23:0] res_wa_r;
  logic [7:0]  res_wd_r;
  logic [15:0] res_fc_r;
  status_t     res_st_r;

  // combinational result of the item in the input register
  logic        emit;
  logic        wv;
  logic [23:0] wa;
  logic [7:0]  wd;
  logic [15:0] fc;
  status_t     st;

  logic        advance;
  logic        s1_fire;
  logic        in_fire;

  logic [23:0]      off_sh;
  logic [15:0]      size_sh;
  logic [15:0]      remain_dec;
  logic [IMG_W-1:0] lim;
  logic [IMG_W-1:0] rec_end;
  logic             exceeds;

  // handshake: the input register moves on when the result register is free
  // or drained this cycle, so a result taken this cycle does not block a new item
  assign advance  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  // apb: one register, selected by the word address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_IMAGE_SIZE) ?
                     {{(DATA_W-IMG_W){1'b0}}, image_size_r} : '0;

  // record bound check, shared by the size and run length fields
  assign off_sh     = {offset_r[15:0], s1_byte_r};
  assign size_sh    = {size_r[7:0], s1_byte_r};
  assign remain_dec = remain_r - 16'd1;
  assign lim        = (image_size_r > IMAGE_LIMIT) ? IMAGE_LIMIT : image_size_r;
  assign rec_end    = {1'b0, offset_r} + {{(IMG_W-16){1'b0}}, size_sh};
  assign exceeds    = rec_end > lim;

  // next parse state
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    offset_nxt = offset_r;
    size_nxt   = size_r;
    remain_nxt = remain_r;
    wptr_nxt   = wptr_r;
    st         = ST_BUSY;
    case (phase_r)
      PH_HEADER: begin
        if (s1_byte_r != header_byte(idx_r)) begin
          st = ST_FAIL;
        end else if (idx_r >= 3'd4) begin
          idx_nxt   = '0;
          phase_nxt = PH_OFFSET;
          if (s1_last_r) st = ST_OK;
        end else begin
          idx_nxt = idx_r + 3'd1;
          if (s1_last_r) st = ST_FAIL;
        end
      end
      PH_OFFSET: begin
        offset_nxt = off_sh;
        if (idx_r >= 3'd2) begin
          idx_nxt = '0;
          if (off_sh == MAGIC_END) begin
            st = ST_OK;
          end else if (s1_last_r) begin
            st = ST_FAIL;
          end else begin
            size_nxt  = '0;
            phase_nxt = PH_SIZE;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
          if (s1_last_r) st = ST_FAIL;
        end
      end
      PH_SIZE: begin
        size_nxt = size_sh;
        if (idx_r >= 3'd1) begin
          idx_nxt = '0;
          if (size_sh != '0) begin
            if (s1_last_r || exceeds) begin
              st = ST_FAIL;
            end else begin
              remain_nxt = size_sh;
              wptr_nxt   = offset_r;
              phase_nxt  = PH_LITERAL;
            end
          end else if (s1_last_r) begin
            st = ST_FAIL;
          end else begin
            phase_nxt = PH_RUNLEN;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
          if (s1_last_r) st = ST_FAIL;
        end
      end
      PH_LITERAL: begin
        wptr_nxt   = wptr_r + 24'd1;
        remain_nxt = remain_dec;
        if (remain_dec == '0) begin
          phase_nxt  = PH_OFFSET;
          offset_nxt = '0;
          idx_nxt    = '0;
          if (s1_last_r) st = ST_OK;
        end else if (s1_last_r) begin
          st = ST_FAIL;
        end
      end
      PH_RUNLEN: begin
        size_nxt = size_sh;
        if (idx_r >= 3'd1) begin
          idx_nxt = '0;
          if (s1_last_r || size_sh == '0 || exceeds) begin
            st = ST_FAIL;
          end else begin
            phase_nxt = PH_FILL;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
          if (s1_last_r) st = ST_FAIL;
        end
      end
      PH_FILL: begin
        phase_nxt  = PH_OFFSET;
        offset_nxt = '0;
        idx_nxt    = '0;
        if (s1_last_r) st = ST_OK;
      end
      PH_DONE: begin
        // finished: drop items, re-arm on the last byte of the file
        if (s1_last_r) begin
          phase_nxt  = PH_HEADER;
          idx_nxt    = '0;
          offset_nxt = '0;
          size_nxt   = '0;
          remain_nxt = '0;
          wptr_nxt   = '0;
        end
      end
      default: begin
        st = ST_FAIL;
      end
    endcase

    // a finish either re-arms at once or waits for the last byte
    if (st != ST_BUSY) begin
      if (s1_last_r) begin
        phase_nxt  = PH_HEADER;
        idx_nxt    = '0;
        offset_nxt = '0;
        size_nxt   = '0;
        remain_nxt = '0;
        wptr_nxt   = '0;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // result fields of the current item
  always_comb begin
    emit = 1'b1;
    wv   = 1'b0;
    wa   = '0;
    wd   = '0;
    fc   = '0;
    case (phase_r)
      PH_LITERAL: begin
        wv = 1'b1;
        wa = wptr_r;
        wd = s1_byte_r;
        fc = 16'd1;
      end
      PH_FILL: begin
        wv = 1'b1;
        wa = offset_r;
        wd = s1_byte_r;
        fc = size_r;
      end
      PH_DONE: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_HEADER;
      idx_r        <= '0;
      offset_r     <= '0;
      size_r       <= '0;
      remain_r     <= '0;
      wptr_r       <= '0;
    end else begin
      if (cfg_write && paddr[2] == REG_IMAGE_SIZE) begin
        image_size_r <= pwdata[IMG_W-1:0];
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r && emit;
      end
      if (s1_fire) begin
        phase_r  <= phase_nxt;
        idx_r    <= idx_nxt;
        offset_r <= offset_nxt;
        size_r   <= size_nxt;
        remain_r <= remain_nxt;
        wptr_r   <= wptr_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_patch_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_fire && emit) begin
      res_wv_r <= wv;
      res_wa_r <= wa;
      res_wd_r <= wd;
      res_fc_r <= fc;
      res_st_r <= st;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = res_wv_r;
  assign out_write_address = res_wa_r;
  assign out_write_data    = res_wd_r;
  assign out_fill_count    = res_fc_r;
  assign out_status        = res_st_r;

endmodule

// ----- src/ipsp_checker.sv -----
// port level checks of the ips patch stream parser, bound to the top level
module ipsp_checker
  import ipsp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_write_valid,
  input logic [23:0]         out_write_address,
  input logic [7:0]          out_write_data,
  input logic [15:0]         out_fill_count,
  input logic [1:0]          out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_valid) &&
      $stable(out_write_address) && $stable(out_write_data) &&
      $stable(out_fill_count) && $stable(out_status))
    else $error("result changed while stalled");

  // items without a write carry zero fields
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |->
      out_write_address == '0 && out_write_data == '0 && out_fill_count == '0)
    else $error("non-write item has nonzero fields");

  // a write or fill always stores at least one byte
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_fill_count != '0)
    else $error("write with zero count");

  // status is busy, ok or fail
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_BUSY || out_status == ST_OK ||
      out_status == ST_FAIL)
    else $error("bad status code");

endmodule

bind ips_patch_stream_parser_core ipsp_checker u_ipsp_checker (.*);
